### rtl/core/ptst_pkg.sv
// shared types and constants for the point step towards target block
package ptst_pkg;

  // coordinate and intermediate widths
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int ROOT_W  = 34;
  localparam int S_W     = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 4;
  localparam int N_W     = 2 * COORD_W;
  localparam int Q_W     = COORD_W;
  localparam int DREM_W  = ROOT_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [COORD_W-1:0] goal_z;
    logic signed [COORD_W-1:0] max_step;
  } ptst_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] next_x;
    logic signed [COORD_W-1:0] next_y;
    logic signed [COORD_W-1:0] next_z;
    logic                      reached;
    logic                      clipped;
  } ptst_out_t;

endpackage

### rtl/core/point_step_towards_target_3d.sv
// top level: 3-d point stepped towards a target by at most a given distance (away from it for a negative step)
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------
//  input   | src_valid | src_stall | src  (start, goal, max_step)
//  output  | dst_valid | dst_stall | dst  (next point, reached, clipped)
//
// one transaction per cycle unless the output stalls; the pipeline has four setup
// stages (difference, products, sum, reach test), 34 square root stages, 32
// divider stages and the output register.
// synchronous reset clears the valid bits only.
// a stalled output with a valid result freezes the whole pipeline, and
// src_stall follows it; nothing is dropped or repeated.
module point_step_towards_target_3d (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  ptst_pkg::ptst_in_t   src,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output ptst_pkg::ptst_out_t  dst
);
  import ptst_pkg::*;

  localparam int PIPE_N = 4 + ROOT_W + Q_W;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] start;
    logic [2:0][COORD_W-1:0] goal;
    logic [2:0][N_W-1:0]     nm;
    logic [2:0]              neg;
    logic                    reached;
  } side1_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] start;
    logic [2:0][COORD_W-1:0] goal;
    logic [2:0]              neg;
    logic                    reached;
  } side2_t;

  logic en;
  logic vpipe [0:PIPE_N-1];

  // stage a
  logic [2:0][COORD_W-1:0] a_start, a_goal;
  logic signed [DIFF_W-1:0] a_diff [0:2];
  logic signed [COORD_W-1:0] a_step;
  // stage b
  logic [2:0][COORD_W-1:0] b_start, b_goal;
  logic [2*DIFF_W-1:0]     b_sq [0:2];
  logic [2:0][N_W-1:0]     b_nm;
  logic [N_W-1:0]          b_ss;
  logic [2:0]              b_neg;
  logic                    b_step_neg;
  // stage c
  logic [2:0][COORD_W-1:0] c_start, c_goal;
  logic [S_W-1:0]          c_s;
  logic [2:0][N_W-1:0]     c_nm;
  logic [N_W-1:0]          c_ss;
  logic [2:0]              c_neg;
  logic                    c_step_neg;
  // stage d
  logic [S_W-1:0]          d_s;
  side1_t                  d_side;

  side1_t side1 [0:ROOT_W-1];
  side2_t side2 [0:Q_W-1];

  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]    quo [0:2];

  logic [DIFF_W-1:0]  abs_d [0:2];
  logic [COORD_W-1:0] ms;

  assign en        = !dst_valid || !dst_stall;
  assign src_stall = !en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_N; i++) vpipe[i] <= 1'b0;
      dst_valid <= 1'b0;
    end else if (en) begin
      vpipe[0] <= src_valid;
      for (int i = 1; i < PIPE_N; i++) vpipe[i] <= vpipe[i-1];
      dst_valid <= vpipe[PIPE_N-1];
    end
  end

  // stage a: differences
  always_ff @(posedge clk) begin
    if (en) begin
      a_start <= {src.start_z, src.start_y, src.start_x};
      a_goal  <= {src.goal_z, src.goal_y, src.goal_x};
      a_step  <= src.max_step;
      a_diff[0] <= DIFF_W'(src.goal_x) - DIFF_W'(src.start_x);
      a_diff[1] <= DIFF_W'(src.goal_y) - DIFF_W'(src.start_y);
      a_diff[2] <= DIFF_W'(src.goal_z) - DIFF_W'(src.start_z);
    end
  end

  // magnitudes for the multipliers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = a_diff[i][DIFF_W-1] ? (~a_diff[i] + 1'b1) : a_diff[i];
    end
    ms = a_step[COORD_W-1] ? (~a_step + 1'b1) : a_step;
  end

  // stage b: squares and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      b_start    <= a_start;
      b_goal     <= a_goal;
      b_step_neg <= a_step[COORD_W-1];
      b_ss       <= ms * ms;
      for (int i = 0; i < 3; i++) begin
        b_sq[i]  <= abs_d[i] * abs_d[i];
        b_nm[i]  <= N_W'(abs_d[i] * ms);
        b_neg[i] <= a_diff[i][DIFF_W-1] ^ a_step[COORD_W-1];
      end
    end
  end

  // stage c: squared length
  always_ff @(posedge clk) begin
    if (en) begin
      c_start    <= b_start;
      c_goal     <= b_goal;
      c_nm       <= b_nm;
      c_ss       <= b_ss;
      c_neg      <= b_neg;
      c_step_neg <= b_step_neg;
      c_s <= S_W'(b_sq[0]) + S_W'(b_sq[1]) + S_W'(b_sq[2]);
    end
  end

  // stage d: reach test
  always_ff @(posedge clk) begin
    if (en) begin
      d_s            <= c_s;
      d_side.start   <= c_start;
      d_side.goal    <= c_goal;
      d_side.nm      <= c_nm;
      d_side.neg     <= c_neg;
      d_side.reached <= (c_s == '0) || (!c_step_neg && (c_s <= S_W'(c_ss)));
    end
  end

  ptst_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_in (d_s),
    .root   (root)
  );

  // side data alongside the root stages
  always_ff @(posedge clk) begin
    if (en) begin
      side1[0] <= d_side;
      for (int i = 1; i < ROOT_W; i++) side1[i] <= side1[i-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ptst_div u_div (
      .clk (clk),
      .en  (en),
      .num (side1[ROOT_W-1].nm[i]),
      .den (root),
      .quo (quo[i])
    );
  end

  // side data alongside the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      side2[0].start   <= side1[ROOT_W-1].start;
      side2[0].goal    <= side1[ROOT_W-1].goal;
      side2[0].neg     <= side1[ROOT_W-1].neg;
      side2[0].reached <= side1[ROOT_W-1].reached;
      for (int i = 1; i < Q_W; i++) side2[i] <= side2[i-1];
    end
  end

  // output: apply offset, saturate, or return the goal
  logic signed [COORD_W+1:0] sum [0:2];
  logic [2:0][COORD_W-1:0]   sat;
  logic [2:0]                clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [COORD_W+1:0] off;
      off = side2[Q_W-1].neg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
      sum[i] = $signed({{2{side2[Q_W-1].start[i][COORD_W-1]}}, side2[Q_W-1].start[i]}) + off;
      if (sum[i] > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
        sat[i]  = {1'b0, {(COORD_W-1){1'b1}}};
        clip[i] = 1'b1;
      end else if (sum[i] < -$signed({3'b001, {(COORD_W-1){1'b0}}})) begin
        sat[i]  = {1'b1, {(COORD_W-1){1'b0}}};
        clip[i] = 1'b1;
      end else begin
        sat[i]  = sum[i][COORD_W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side2[Q_W-1].reached) begin
        dst.next_x  <= side2[Q_W-1].goal[0];
        dst.next_y  <= side2[Q_W-1].goal[1];
        dst.next_z  <= side2[Q_W-1].goal[2];
        dst.reached <= 1'b1;
        dst.clipped <= 1'b0;
      end else begin
        dst.next_x  <= sat[0];
        dst.next_y  <= sat[1];
        dst.next_z  <= sat[2];
        dst.reached <= 1'b0;
        dst.clipped <= |clip;
      end
    end
  end

endmodule

### rtl/core/ptst_sqrt.sv
// pipelined floor square root, one root bit per stage
module ptst_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ptst_pkg::S_W-1:0]    rad_in,
  output logic [ptst_pkg::ROOT_W-1:0] root
);
  import ptst_pkg::*;

  logic [S_W-1:0]    rad_q  [1:ROOT_W];
  logic [REM_W-1:0]  rem_q  [1:ROOT_W];
  logic [ROOT_W-1:0] root_q [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [S_W-1:0]    rad_c;
    logic [REM_W-1:0]  rem_c;
    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_c;
    logic              take;

    if (k == 0) begin : g_first
      assign rad_c  = rad_in;
      assign rem_c  = '0;
      assign root_c = '0;
    end else begin : g_rest
      assign rad_c  = rad_q[k];
      assign rem_c  = rem_q[k];
      assign root_c = root_q[k];
    end

    // bring down the next bit pair and try the next root bit
    assign cand  = {rem_c[REM_W-3:0], rad_c[S_W-1 -: 2]};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, root_c, 2'b01};
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1]  <= rad_c << 2;
        rem_q[k+1]  <= take ? (cand - trial) : cand;
        root_q[k+1] <= {root_c[ROOT_W-2:0], take};
      end
    end
  end

  assign root = root_q[ROOT_W];

endmodule

### rtl/core/ptst_div.sv
// pipelined restoring divider, one quotient bit per stage
module ptst_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ptst_pkg::N_W-1:0]    num,
  input  logic [ptst_pkg::ROOT_W-1:0] den,
  output logic [ptst_pkg::Q_W-1:0]    quo
);
  import ptst_pkg::*;

  logic [DREM_W-1:0] rem_q [1:Q_W];
  logic [Q_W-1:0]    lo_q  [1:Q_W];
  logic [Q_W-1:0]    quo_q [1:Q_W];
  logic [ROOT_W-1:0] den_q [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DREM_W-1:0] rem_c;
    logic [Q_W-1:0]    lo_c;
    logic [Q_W-1:0]    quo_c;
    logic [ROOT_W-1:0] den_c;
    logic [DREM_W-1:0] cand;
    logic [DREM_W-1:0] dd;
    logic              take;

    // upper half starts as the partial remainder, below the divisor
    if (k == 0) begin : g_first
      assign rem_c = {{(DREM_W-Q_W){1'b0}}, num[N_W-1:Q_W]};
      assign lo_c  = num[Q_W-1:0];
      assign quo_c = '0;
      assign den_c = den;
    end else begin : g_rest
      assign rem_c = rem_q[k];
      assign lo_c  = lo_q[k];
      assign quo_c = quo_q[k];
      assign den_c = den_q[k];
    end

    assign cand = {rem_c[DREM_W-2:0], lo_c[Q_W-1]};
    assign dd   = {1'b0, den_c};
    assign take = (cand >= dd);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= take ? (cand - dd) : cand;
        lo_q[k+1]  <= lo_c << 1;
        quo_q[k+1] <= {quo_c[Q_W-2:0], take};
        den_q[k+1] <= den_c;
      end
    end
  end

  assign quo = quo_q[Q_W];

endmodule

### rtl/core/ptst_check.sv
// port-level checker for the point step block, with its bind
module ptst_check (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input ptst_pkg::ptst_in_t  src,
  input logic                dst_valid,
  input logic                dst_stall,
  input ptst_pkg::ptst_out_t dst
);
  import ptst_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst))
    else $error("stalled result changed");

  // input side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> dst_valid && dst_stall)
    else $error("input stalled without output backpressure");

  // the goal itself is never clipped
  a_reach_clip: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> !(dst.reached && dst.clipped))
    else $error("reached and clipped together");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result valid after reset");

endmodule

bind point_step_towards_target_3d ptst_check u_ptst_check (.*);

### tb/sv/point_step_towards_target_3d_tb.sv
// testbench for the 3-d point step towards target block
module point_step_towards_target_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptst_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  ptst_in_t src = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  ptst_out_t dst;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int unsigned cycles = 0;
  ptst_out_t expected_points[$];

  localparam int LATENCY = 71;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  point_step_towards_target_3d dut (
    .clk(clk), .rst(rst), .src_valid(src_valid), .src_stall(src_stall),
    .src(src), .dst_valid(dst_valid), .dst_stall(dst_stall), .dst(dst)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor square root of a value below 2^68
  function automatic logic [33:0] floor_root(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // predicted next point for one request
  function automatic ptst_out_t step_point(ptst_in_t t);
    ptst_out_t o;
    logic signed [32:0] st [3];
    logic signed [32:0] gl [3];
    logic signed [32:0] df [3];
    logic [32:0] ad;
    logic [67:0] sq;
    logic [33:0] root;
    logic [31:0] astep;
    logic [63:0] q;
    logic signed [67:0] sum;
    logic signed [31:0] res [3];
    st[0] = t.start_x; st[1] = t.start_y; st[2] = t.start_z;
    gl[0] = t.goal_x;  gl[1] = t.goal_y;  gl[2] = t.goal_z;
    sq = '0;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      df[i] = gl[i] - st[i];
      ad = df[i][32] ? -df[i] : df[i];
      sq = sq + {35'd0, ad} * {35'd0, ad};
    end
    astep = t.max_step[31] ? -t.max_step : t.max_step;
    if (sq == 0) o.reached = 1'b1;
    else if (!t.max_step[31] && sq <= {36'd0, astep} * {36'd0, astep}) o.reached = 1'b1;
    if (o.reached) begin
      for (int i = 0; i < 3; i++) res[i] = gl[i][31:0];
    end else begin
      root = floor_root(sq);
      for (int i = 0; i < 3; i++) begin
        ad = df[i][32] ? -df[i] : df[i];
        q = ({31'd0, ad} * {32'd0, astep}) / {30'd0, root};
        sum = st[i];
        if (df[i][32] != t.max_step[31]) sum = sum - $signed({4'd0, q});
        else sum = sum + $signed({4'd0, q});
        if (sum > 68'sd2147483647) begin
          res[i] = 32'h7fffffff; o.clipped = 1'b1;
        end else if (sum < -68'sd2147483648) begin
          res[i] = 32'h80000000; o.clipped = 1'b1;
        end else res[i] = sum[31:0];
      end
    end
    o.next_x = res[0]; o.next_y = res[1]; o.next_z = res[2];
    return o;
  endfunction

  // send one transaction and queue its prediction
  task automatic send_request(ptst_in_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src <= t;
    src_valid <= 1'b1;
    do @(posedge clk); while (src_stall);
    expected_points.push_back(step_point(t));
  endtask

  // receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    dst_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", dst);
      end else begin
        ptst_out_t e;
        e = expected_points.pop_front();
        if (dst.next_x !== e.next_x || dst.next_y !== e.next_y ||
            dst.next_z !== e.next_z || dst.reached !== e.reached ||
            dst.clipped !== e.clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h r=%b c=%b got x=%h y=%h z=%h r=%b c=%b",
                     e.next_x, e.next_y, e.next_z, e.reached, e.clipped,
                     dst.next_x, dst.next_y, dst.next_z, dst.reached, dst.clipped);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic ptst_in_t make_request(int sx, int sy, int sz, int gx, int gy, int gz,
                                            int ms);
    ptst_in_t t;
    t.start_x = sx; t.start_y = sy; t.start_z = sz;
    t.goal_x = gx; t.goal_y = gy; t.goal_z = gz; t.max_step = ms;
    return t;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      2: return $signed($urandom_range(20 << 16)) - (10 << 16);
      default: return $signed($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  // directed: extremes and each special case
  task automatic test_directed();
    int mx;
    int mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_request(make_request(5, 6, 7, 5, 6, 7, 100));
    send_request(make_request(5, 6, 7, 5, 6, 7, -100));
    send_request(make_request(mx, mx, mx, mx, mx, mx, mn));
    send_request(make_request(0, 0, 0, 10 << 16, 0, 0, 0));
    send_request(make_request(0, 0, 0, 10 << 16, 0, 0, 3 << 16));
    send_request(make_request(0, 0, 0, 3 << 16, 4 << 16, 0, 5 << 16));
    send_request(make_request(0, 0, 0, 3 << 16, 4 << 16, 0, (5 << 16) - 1));
    send_request(make_request(0, 0, 0, 3 << 16, 4 << 16, 0, -(1 << 16)));
    send_request(make_request(mn, mn, mn, mx, mx, mx, mx));
    send_request(make_request(mx, mx, mx, mn, mn, mn, mx));
    send_request(make_request(mn, mn, mn, mx, mx, mx, mn));
    send_request(make_request(mx, mx, mx, mn, mn, mn, mn));
    send_request(make_request(mx, 0, mn, mn, 0, mx, mn));
    send_request(make_request(mx - 5, 0, 0, mx, 1, 0, -(1 << 20)));
    send_request(make_request(0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(0, 0, 0, -1, -1, -1, mx));
    send_request(make_request(0, 0, 0, 1, 1, 1, 1));
    send_request(make_request(-1, -1, -1, 0, 0, 0, -1));
    send_request(make_request(1 << 16, 2 << 16, 3 << 16, -(7 << 16), 9 << 16, 1, 1 << 15));
  endtask

  // random requests under one idling mix
  task automatic test_random(int n, int idle, int stall);
    ptst_in_t t;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      t.start_x = rand_coord(); t.start_y = rand_coord(); t.start_z = rand_coord();
      if ($urandom_range(7) == 0) begin
        t.goal_x = t.start_x; t.goal_y = t.start_y; t.goal_z = t.start_z;
      end else begin
        t.goal_x = rand_coord(); t.goal_y = rand_coord(); t.goal_z = rand_coord();
      end
      case ($urandom_range(3))
        0: t.max_step = $urandom();
        1: t.max_step = $signed($urandom_range(1 << 22)) - (1 << 21);
        2: t.max_step = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        default: t.max_step = $urandom_range(1 << 24);
      endcase
      send_request(t);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 51, 0);
    test_random(100, 0, 51);
    test_random(100, 18, 18);
    src_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### point_step_towards_target_3d.f
rtl/core/ptst_pkg.sv
rtl/core/ptst_sqrt.sv
rtl/core/ptst_div.sv
rtl/core/point_step_towards_target_3d.sv
rtl/core/ptst_check.sv
tb/sv/point_step_towards_target_3d_tb.sv
